// ----- hw/rtl/spag_pkg.sv -----
// Shared widths, constants and payload types for the spectrum power average block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package spag_pkg;

   // Field widths of the request and result channels.
   localparam int DATA_WIDTH    = 16;
   localparam int BIN_OUT_WIDTH = 7;
   localparam int LEVEL_WIDTH   = 8;

   // One bin power is at most 2^31, so it needs 32 bits.
   localparam int POWER_WIDTH = 32;
   localparam int SQ_WIDTH    = POWER_WIDTH - 1;

   // Averaging window: a fixed eight frames, so the mean is a shift by three.
   localparam int WINDOW_FRAMES = 8;
   localparam int SLOT_WIDTH    = $clog2(WINDOW_FRAMES);
   localparam int SUM_WIDTH     = POWER_WIDTH + SLOT_WIDTH;

   // Level scaling.
   localparam int SHIFT_DC = 12;
   localparam int SHIFT_AC = 14;
   localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX = '1;

   // Default transform size.
   localparam int FFT_POINTS_DEFAULT = 128;

   // Register port.
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic REG_NOISE_CAPTURE = 1'b0;

   // One row of the power history: the bin's power in every frame slot.
   typedef logic [WINDOW_FRAMES-1:0][POWER_WIDTH-1:0] hist_row_type;

   // Result payload.
   typedef struct packed {
      logic [BIN_OUT_WIDTH-1:0] bin;
      logic [LEVEL_WIDTH-1:0]   level;
   } rsp_payload_type;

   // A result pushed from the pipeline into the output buffer.
   typedef struct packed {
      logic            valid;
      rsp_payload_type data;
   } rsp_push_type;

endpackage

`default_nettype wire

// ----- hw/rtl/spag_req_if.sv -----
// Request channel: one complex FFT bin per request.
// Depends on spag_pkg for the field width.
`default_nettype none

interface spag_req_if;
   import spag_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] re;
   logic signed [DATA_WIDTH-1:0] im;

   modport source (output valid, output re, output im, input ready);
   modport sink   (input valid, input re, input im, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/spag_rsp_if.sv -----
// Result channel: bin index and gated level.
// Depends on spag_pkg for the field widths.
`default_nettype none

interface spag_rsp_if;
   import spag_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [BIN_OUT_WIDTH-1:0] bin;
   logic [LEVEL_WIDTH-1:0]   level;

   modport source (output valid, output bin, output level, input ready);
   modport sink   (input valid, input bin, input level, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/spag_skid.sv -----
// Output register with one skid entry that decouples the pipeline from the result channel.
// Depends on spag_pkg and spag_rsp_if.
`default_nettype none

module spag_skid (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire spag_pkg::rsp_push_type push,
   output logic                       has_room,
   spag_rsp_if.source                 rsp_bus
);
   import spag_pkg::*;

   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff, out_data_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type skid_data_ff, skid_data_in;
   logic            pop;

   assign pop = out_valid_ff && rsp_bus.ready;

   // The pipeline only pushes while the skid entry is free.
   assign has_room = !skid_valid_ff;

   // Pop first, then place the pushed result behind whatever remains.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (push.valid) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_data_in  = push.data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.bin   = out_data_ff.bin;
   assign rsp_bus.level = out_data_ff.level;

endmodule

`default_nettype wire

// ----- hw/rtl/spectrum_power_average_noise_gate_top.sv -----
// Outside capture mode a request passes stages one to three and the output register to rsp_bus.
// Throughput: one request per cycle; the pipeline stalls only when the output buffer is full.
// The per-bin running sums are read when a request enters and written back from stage two.
// Reset: synchronous, active high. Afterward a clearing sweep zeroes all FFT_POINTS/2+1 rows
// (65 by default) of the history, sum and floor memories; no request is taken meanwhile.
`default_nettype none

module spectrum_power_average_noise_gate_top #(
   parameter int FFT_POINTS = spag_pkg::FFT_POINTS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   spag_req_if.sink                                 req_bus,
   spag_rsp_if.source                               rsp_bus,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [spag_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [spag_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic      [spag_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                     pready
);
   import spag_pkg::*;

   localparam int HalfBins = FFT_POINTS / 2;
   localparam int BinCount = HalfBins + 1;
   localparam int BinWidth = $clog2(BinCount);

   // Register port.
   logic noise_capture_ff;
   logic csr_write;

   // Control.
   logic                  adv;
   logic                  accept;
   logic                  clear_ff;
   logic [BinWidth-1:0]   clr_idx_ff;
   logic [BinWidth-1:0]   bin_ff;
   logic [SLOT_WIDTH-1:0] slot_ff;

   // Memories.
   hist_row_type         hist_mem  [BinCount];
   logic [SUM_WIDTH-1:0] sum_mem   [BinCount];
   logic [POWER_WIDTH-1:0] floor_mem [BinCount];

   // Stage one: squares and memory read data.
   logic                         s1_valid_ff;
   logic [BinWidth-1:0]          s1_bin_ff;
   logic [SLOT_WIDTH-1:0]        s1_slot_ff;
   logic                         s1_capture_ff;
   logic [SQ_WIDTH-1:0]          sq_re_ff, sq_im_ff;
   hist_row_type                 hist_rd_ff;
   logic [SUM_WIDTH-1:0]         sum_rd_ff;
   logic [POWER_WIDTH-1:0]       floor_rd_ff;
   logic signed [2*DATA_WIDTH-1:0] re_sq, im_sq;
   logic [POWER_WIDTH-1:0]       s1_power;
   logic [SUM_WIDTH-1:0]         s1_diff;

   // Stage two: power and sum without the leaving frame.
   logic                   s2_valid_ff;
   logic [BinWidth-1:0]    s2_bin_ff;
   logic                   s2_capture_ff;
   logic [POWER_WIDTH-1:0] s2_power_ff;
   logic [SUM_WIDTH-1:0]   s2_diff_ff;
   logic [POWER_WIDTH-1:0] s2_floor_ff;
   logic [SUM_WIDTH-1:0]   s2_sum;

   // Stage three: new window sum.
   logic                   s3_valid_ff;
   logic [BinWidth-1:0]    s3_bin_ff;
   logic                   s3_capture_ff;
   logic [SUM_WIDTH-1:0]   s3_sum_ff;
   logic [POWER_WIDTH-1:0] s3_floor_ff;
   logic [POWER_WIDTH-1:0] s3_mean;
   logic [POWER_WIDTH-1:0] s3_shifted;
   logic [LEVEL_WIDTH-1:0] s3_level;

   rsp_push_type push;
   logic         has_room;

   // Configuration register write and read.
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_capture_ff <= 1'b0;
      end else if (csr_write && paddr[2] == REG_NOISE_CAPTURE) begin
         noise_capture_ff <= pwdata[0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_NOISE_CAPTURE) begin
         prdata = {{(CSR_DATA_WIDTH-1){1'b0}}, noise_capture_ff};
      end
   end

   // All stages move together whenever the output buffer can take a result.
   assign adv           = has_room;
   assign req_bus.ready = adv && !clear_ff;
   assign accept        = req_bus.valid && req_bus.ready;

   // Clearing sweep after reset, one memory row per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff   <= 1'b1;
         clr_idx_ff <= '0;
      end else if (clear_ff) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
         if (clr_idx_ff == BinWidth'(BinCount - 1)) begin
            clear_ff <= 1'b0;
         end
      end
   end

   // Bin counter and frame slot; the slot advances after the last bin.
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_ff  <= '0;
         slot_ff <= '0;
      end else if (accept) begin
         if (bin_ff == BinWidth'(HalfBins)) begin
            bin_ff  <= '0;
            slot_ff <= slot_ff + 1'b1;
         end else begin
            bin_ff <= bin_ff + 1'b1;
         end
      end
   end

   // Squares of the incoming bin.
   assign re_sq = req_bus.re * req_bus.re;
   assign im_sq = req_bus.im * req_bus.im;

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Stage payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_bin_ff     <= bin_ff;
         s1_slot_ff    <= slot_ff;
         s1_capture_ff <= noise_capture_ff;
         sq_re_ff      <= re_sq[SQ_WIDTH-1:0];
         sq_im_ff      <= im_sq[SQ_WIDTH-1:0];
         s2_bin_ff     <= s1_bin_ff;
         s2_capture_ff <= s1_capture_ff;
         s2_power_ff   <= s1_power;
         s2_diff_ff    <= s1_diff;
         s2_floor_ff   <= floor_rd_ff;
         s3_bin_ff     <= s2_bin_ff;
         s3_capture_ff <= s2_capture_ff;
         s3_sum_ff     <= s2_sum;
         s3_floor_ff   <= s2_floor_ff;
      end
   end

   // Stage one: form the power and drop the frame that leaves the window.
   assign s1_power = {1'b0, sq_re_ff} + {1'b0, sq_im_ff};
   assign s1_diff  = sum_rd_ff - SUM_WIDTH'(hist_rd_ff[s1_slot_ff]);

   // Stage two: add the new frame.
   assign s2_sum = s2_diff_ff + SUM_WIDTH'(s2_power_ff);

   // History memory: read a whole row on entry, write one slot in stage one.
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         hist_mem[clr_idx_ff] <= '0;
      end else if (adv && s1_valid_ff) begin
         hist_mem[s1_bin_ff][s1_slot_ff] <= s1_power;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hist_rd_ff <= hist_mem[bin_ff];
      end
   end

   // Running sum memory: read on entry, written from stage two.
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         sum_mem[clr_idx_ff] <= '0;
      end else if (adv && s2_valid_ff) begin
         sum_mem[s2_bin_ff] <= s2_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_rd_ff <= sum_mem[bin_ff];
      end
   end

   // Noise floor memory: read on entry, written from stage three in capture mode.
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         floor_mem[clr_idx_ff] <= '0;
      end else if (adv && s3_valid_ff && s3_capture_ff) begin
         floor_mem[s3_bin_ff] <= s3_mean;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         floor_rd_ff <= floor_mem[bin_ff];
      end
   end

   // Stage three: mean, gate against the floor, scale and saturate.
   assign s3_mean    = s3_sum_ff[SUM_WIDTH-1:SLOT_WIDTH];
   assign s3_shifted = (s3_bin_ff == '0) ? (s3_mean >> SHIFT_DC) : (s3_mean >> SHIFT_AC);

   always_comb begin
      s3_level = '0;
      if (s3_mean > s3_floor_ff) begin
         if (|s3_shifted[POWER_WIDTH-1:LEVEL_WIDTH]) begin
            s3_level = LEVEL_MAX;
         end else begin
            s3_level = s3_shifted[LEVEL_WIDTH-1:0];
         end
      end
   end

   assign push.valid      = adv && s3_valid_ff && !s3_capture_ff;
   assign push.data.bin   = BIN_OUT_WIDTH'(s3_bin_ff);
   assign push.data.level = s3_level;

   spag_skid u_skid (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .has_room (has_room),
      .rsp_bus  (rsp_bus)
   );

   // The memories are swept clean right after reset.
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> clear_ff)
      else $error("clearing sweep did not start after reset");

   // After the last bin the counter wraps and the frame slot advances.
   assert property (@(posedge clock) disable iff (reset)
      (accept && bin_ff == BinWidth'(HalfBins))
      |=> (bin_ff == '0 && slot_ff == $past(slot_ff) + 1'b1))
      else $error("bin counter or frame slot did not advance at frame end");

   // A result leaving the pipeline shows up on the result channel.
   assert property (@(posedge clock) disable iff (reset) push.valid |=> rsp_bus.valid)
      else $error("result pushed from the pipeline was lost");

endmodule

`default_nettype wire

// ----- bench/tb_spectrum_power_average_noise_gate_top.sv -----
// Self-checking bench for the spectrum power average and noise gate block.
// It streams FFT bins in both modes and checks each result's bin and level against a predictor.
// Depends on spag_pkg, spag_req_if, spag_rsp_if and spectrum_power_average_noise_gate_top.

module tb_spectrum_power_average_noise_gate_top;
   timeunit 1ns;
   timeprecision 1ps;

   import spag_pkg::*;

   localparam int FFT_POINTS   = FFT_POINTS_DEFAULT;
   localparam int HALF_BINS    = FFT_POINTS / 2;
   localparam int BIN_COUNT    = HALF_BINS + 1;
   localparam int RANDOM_ITEMS = 1080;
   localparam int CALM_ITEMS   = 160;
   localparam int DRAIN_CYCLES = 10;
   localparam int STALL_LIMIT  = 2000;

   // Register map and mode codes.
   localparam logic [CSR_ADDR_WIDTH-1:0] NOISE_CAPTURE_ADDR =
      CSR_ADDR_WIDTH'(4 * REG_NOISE_CAPTURE);
   localparam logic MODE_EMIT    = 1'b0;
   localparam logic MODE_CAPTURE = 1'b1;

   typedef enum logic {ROW_BIN, ROW_MODE} row_kind_type;

   // One row of the directed stimulus: a bin request or a mode change.
   typedef struct {
      row_kind_type                 kind;
      logic signed [DATA_WIDTH-1:0] re;
      logic signed [DATA_WIDTH-1:0] im;
      logic                         mode;
      bit                           typed;
      rsp_payload_type              want;
   } stim_row_type;

   logic                      clock;
   logic                      reset;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   spag_req_if req_bus ();
   spag_rsp_if rsp_bus ();

   spectrum_power_average_noise_gate_top #(
      .FFT_POINTS(FFT_POINTS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Predictor state: per-slot bin power, running window sums and learned floors.
   logic [POWER_WIDTH-1:0] history_pow [WINDOW_FRAMES][BIN_COUNT] = '{default: '0};
   logic [SUM_WIDTH-1:0]   bin_sum [BIN_COUNT] = '{default: '0};
   logic [POWER_WIDTH-1:0] floor_pow [BIN_COUNT] = '{default: '0};
   logic [SLOT_WIDTH-1:0]  slot_ptr = '0;
   int                     bin_ptr = 0;
   logic                   capture_mode = MODE_EMIT;

   rsp_payload_type pending_levels[$];
   int              mismatch_count = 0;
   int              gap_rate = 2;
   bit              calm = 1'b0;

   const int unsigned amp_steps[6] = '{64, 512, 2048, 6000, 16384, 32768};

   // 50 MHz clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Update the window for one bin and work out the gated level it yields.
   task automatic predict_bin(input logic signed [DATA_WIDTH-1:0] re_v,
                              input logic signed [DATA_WIDTH-1:0] im_v,
                              output bit emitted, output rsp_payload_type res);
      logic signed [POWER_WIDTH-1:0] re_sq;
      logic signed [POWER_WIDTH-1:0] im_sq;
      logic [POWER_WIDTH-1:0]        pw;
      logic [POWER_WIDTH-1:0]        mean;
      logic [POWER_WIDTH-1:0]        scaled;
      re_sq = re_v * re_v;
      im_sq = im_v * im_v;
      pw = re_sq + im_sq;
      bin_sum[bin_ptr] = bin_sum[bin_ptr] - SUM_WIDTH'(history_pow[slot_ptr][bin_ptr])
                         + SUM_WIDTH'(pw);
      history_pow[slot_ptr][bin_ptr] = pw;
      mean = POWER_WIDTH'(bin_sum[bin_ptr] / WINDOW_FRAMES);
      res = '0;
      emitted = (capture_mode == MODE_EMIT);
      if (capture_mode == MODE_CAPTURE) begin
         floor_pow[bin_ptr] = mean;
      end else begin
         // The DC bin is scaled less than the others; large means clip at full scale.
         scaled = (bin_ptr == 0) ? (mean >> SHIFT_DC) : (mean >> SHIFT_AC);
         res.bin = BIN_OUT_WIDTH'(bin_ptr);
         if (mean > floor_pow[bin_ptr]) begin
            res.level = (scaled > POWER_WIDTH'(LEVEL_MAX)) ? LEVEL_MAX : scaled[LEVEL_WIDTH-1:0];
         end
      end
      // The slot moves on once the last bin of the half spectrum is in.
      if (bin_ptr == HALF_BINS) begin
         bin_ptr = 0;
         slot_ptr = slot_ptr + 1'b1;
      end else begin
         bin_ptr++;
      end
   endtask

   // Offer one bin request, possibly after a gap, and predict it once accepted.
   task automatic send_bin(input logic signed [DATA_WIDTH-1:0] re_v,
                           input logic signed [DATA_WIDTH-1:0] im_v,
                           input bit typed, input rsp_payload_type typed_res);
      bit              emitted;
      rsp_payload_type res;
      @(negedge clock);
      if (!calm && gap_rate != 0 && $urandom_range(0, 7) < gap_rate) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.re    = re_v;
      req_bus.im    = im_v;
      do @(posedge clock); while (!req_bus.ready);
      predict_bin(re_v, im_v, emitted, res);
      if (emitted) begin
         pending_levels.push_back(typed ? typed_res : res);
      end
   endtask

   // Stop requests and let the pipeline empty before touching the register.
   task automatic settle_block();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the mode register, then read it back.
   task automatic write_mode(input logic mode);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = NOISE_CAPTURE_ADDR;
      pwdata  = CSR_DATA_WIDTH'(mode);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      capture_mode = mode;
      @(negedge clock);
      pwrite  = 1'b0;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DATA_WIDTH'(mode)) begin
         report_mismatch("noise_capture readback", prdata, mode);
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   // Mostly values within the phase amplitude, with extremes and raw bit patterns mixed in.
   function automatic logic signed [DATA_WIDTH-1:0] pick_component(input int unsigned amp);
      int v;
      case ($urandom_range(0, 15))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'($urandom());
         default: begin
            v = int'($urandom_range(0, 2 * amp)) - int'(amp);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return DATA_WIDTH'(v);
         end
      endcase
   endfunction

   // Result side: ready drops in bursts, except near the end of the run.
   initial begin : result_sink
      rsp_bus.ready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         repeat ($urandom_range(1, 40)) @(negedge clock);
      end
   end

   // Compare each result with the oldest predicted level.
   always @(posedge clock) begin : level_check
      rsp_payload_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_levels.size() == 0) begin
            report_mismatch("unexpected result, bin", rsp_bus.bin, -1);
         end else begin
            want = pending_levels.pop_front();
            if (rsp_bus.bin !== want.bin) begin
               report_mismatch("bin", rsp_bus.bin, want.bin);
            end
            if (rsp_bus.level !== want.level) begin
               report_mismatch("level", rsp_bus.level, want.level);
            end
         end
      end
   end

   // End the run when no handshake of any kind happens for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (psel && penable && pready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      stim_row_type directed_rows[20];
      int           sent;
      int           phase;
      int           span;
      int unsigned  amp;
      bit           want_capture;

      // Start of a frame: zero power, full-scale corners, tiny power that averages to zero,
      // a mode change in mid-frame, and a few bins whose floors are learned in capture mode.
      directed_rows = '{
         '{ROW_BIN,  16'sd0,      16'sd0,      MODE_EMIT,    1'b1, '{bin: 7'd0,  level: 8'd0}},
         '{ROW_BIN,  16'sh8000,   16'sh8000,   MODE_EMIT,    1'b1, '{bin: 7'd1,  level: 8'd255}},
         '{ROW_BIN,  16'sh7FFF,   16'sh7FFF,   MODE_EMIT,    1'b1, '{bin: 7'd2,  level: 8'd255}},
         '{ROW_BIN,  16'sh7FFF,   16'sh8000,   MODE_EMIT,    1'b1, '{bin: 7'd3,  level: 8'd255}},
         '{ROW_BIN,  16'sd1,      -16'sd1,     MODE_EMIT,    1'b1, '{bin: 7'd4,  level: 8'd0}},
         '{ROW_BIN,  16'sd3620,   16'sd0,      MODE_EMIT,    1'b0, '0},
         '{ROW_BIN,  -16'sd1000,  16'sd2000,   MODE_EMIT,    1'b0, '0},
         '{ROW_BIN,  16'sd724,    -16'sd724,   MODE_EMIT,    1'b0, '0},
         '{ROW_MODE, 16'sd0,      16'sd0,      MODE_CAPTURE, 1'b0, '0},
         '{ROW_BIN,  16'sd3000,   16'sd3000,   MODE_CAPTURE, 1'b0, '0},
         '{ROW_BIN,  16'sh8000,   16'sh8000,   MODE_CAPTURE, 1'b0, '0},
         '{ROW_BIN,  16'sd100,    -16'sd100,   MODE_CAPTURE, 1'b0, '0},
         '{ROW_BIN,  16'sd0,      16'sd0,      MODE_CAPTURE, 1'b0, '0},
         '{ROW_MODE, 16'sd0,      16'sd0,      MODE_EMIT,    1'b0, '0},
         '{ROW_BIN,  16'sd5000,   16'sd5000,   MODE_EMIT,    1'b0, '0},
         '{ROW_BIN,  16'sh7FFF,   16'sd0,      MODE_EMIT,    1'b0, '0},
         '{ROW_BIN,  16'sh8000,   16'sd0,      MODE_EMIT,    1'b1, '{bin: 7'd14, level: 8'd255}},
         '{ROW_BIN,  16'sd0,      16'sh8000,   MODE_EMIT,    1'b1, '{bin: 7'd15, level: 8'd255}},
         '{ROW_BIN,  16'sd0,      16'sd0,      MODE_EMIT,    1'b1, '{bin: 7'd16, level: 8'd0}},
         '{ROW_BIN,  -16'sd1,     16'sd0,      MODE_EMIT,    1'b1, '{bin: 7'd17, level: 8'd0}}
      };

      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.re    = '0;
      req_bus.im    = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_mode(MODE_EMIT);

      // Directed part.
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_MODE) begin
            settle_block();
            write_mode(directed_rows[r].mode);
         end else begin
            send_bin(directed_rows[r].re, directed_rows[r].im,
                     directed_rows[r].typed, directed_rows[r].want);
         end
      end

      // Random phases: each one picks a mode, an amplitude and a gap rate. Capture phases
      // learn floors at one level, and later phases at other levels open or close the gate.
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         settle_block();
         if (phase == 0) begin
            want_capture = 1'b1;
         end else if (phase == 1 || sent >= RANDOM_ITEMS - CALM_ITEMS) begin
            want_capture = 1'b0;
         end else begin
            want_capture = ($urandom_range(0, 3) == 0);
         end
         write_mode(want_capture ? MODE_CAPTURE : MODE_EMIT);
         amp      = amp_steps[$urandom_range(0, 5)];
         gap_rate = $urandom_range(0, 4);
         span     = $urandom_range(30, 140);
         for (int k = 0; k < span && sent < RANDOM_ITEMS; k++) begin
            calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
            send_bin(pick_component(amp), pick_component(amp), 1'b0, '0);
            sent++;
         end
         phase++;
      end

      settle_block();
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
